@@ src/krt_pkg.sv @@
package krt_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths.
  localparam int KIND_W   = 3;
  localparam int KEY_W    = 32;
  localparam int NAME_W   = 64;
  localparam int SCORE_W  = 16;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 7;

  // Stream word widths, padded to whole bytes.
  localparam int IN_FIELDS_W  = KEY_W + NAME_W + SCORE_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STATUS_W + KEY_W + NAME_W + SCORE_W + TOTAL_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Request kinds; the remaining codes are ignored requests.
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD          = 3'd0,
    KIND_DELETE       = 3'd1,
    KIND_REVISE       = 3'd2,
    KIND_LOOKUP_KEY   = 3'd3,
    KIND_LOOKUP_SCORE = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_DUPLICATE = 2'd2,
    STATUS_FULL      = 2'd3
  } status_e;

  // One table record.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [NAME_W-1:0]  name;
    logic [SCORE_W-1:0] score;
  } rec_t;

  // Ring control from the controller to the cell row.
  typedef struct packed {
    logic shift;
    logic wr_en;
  } ring_ctl_t;

  // One result word.
  typedef struct packed {
    status_e            status;
    rec_t               found;
    logic [TOTAL_W-1:0] total;
  } result_t;

endpackage

@@ src/krt_cell.sv @@
module krt_cell
  import krt_pkg::*;
(
  input  logic clk_i,
  input  logic shift_i,
  input  rec_t rec_i,
  output rec_t rec_o
);

  rec_t rec_q;

  // Take the neighbor's record whenever the ring advances.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      rec_q <= rec_i;
    end
  end

  assign rec_o = rec_q;

endmodule

@@ src/krt_ctrl.sv @@
module krt_ctrl
  import krt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [KIND_W-1:0] s_kind_i,
  input  rec_t              s_rec_i,
  input  rec_t              head_rec_i,
  output ring_ctl_t         ring_ctl_o,
  output rec_t              wr_rec_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output result_t           m_result_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               found_q, found_d;
  logic               out_valid_q, out_valid_d;
  logic [KIND_W-1:0]  kind_q, kind_d;
  rec_t               req_q, req_d;
  rec_t               found_rec_q, found_rec_d;
  rec_t               last_q, last_d;
  rec_t               cand_q, cand_d;
  result_t            res_q, res_d;
  result_t            out_q, out_d;

  logic [CNT_W:0]     pos;
  logic [CNT_W:0]     cnt;
  logic               in_range;
  logic               key_hit;
  logic               score_hit;
  logic               hit;
  logic               first;
  logic               found_end;
  logic               wr_en;
  rec_t               wr_rec;
  rec_t               head_next;
  rec_t               found_end_rec;
  logic               is_last;
  logic               is_prev;
  logic               last_step;
  logic               scanning;
  logic               load_out;

  // Position of the entry at the head of the ring against the fill count.
  assign pos       = (CNT_W + 1)'(idx_q);
  assign cnt       = (CNT_W + 1)'(count_q);
  assign in_range  = pos < cnt;
  assign key_hit   = in_range && (head_rec_i.key == req_q.key);
  assign score_hit = in_range && (head_rec_i.score == req_q.score);
  assign is_last   = (pos + 1'b1) == cnt;
  assign is_prev   = (pos + 2'd2) == cnt;
  assign last_step = idx_q == IDX_W'(TABLE_DEPTH - 1);
  assign scanning  = state_q == ST_SCAN;

  // Match and write decisions for the record passing the head.
  always_comb begin
    hit    = 1'b0;
    wr_en  = 1'b0;
    wr_rec = head_rec_i;
    unique case (kind_q)
      KIND_ADD: begin
        hit    = key_hit;
        wr_en  = (pos == cnt) && !found_q;
        wr_rec = req_q;
      end
      KIND_DELETE: begin
        hit    = key_hit;
        wr_en  = key_hit && !found_q;
        wr_rec = last_q;
      end
      KIND_REVISE: begin
        hit          = key_hit;
        wr_en        = key_hit && !found_q;
        wr_rec.key   = head_rec_i.key;
        wr_rec.name  = req_q.name;
        wr_rec.score = req_q.score;
      end
      KIND_LOOKUP_KEY:   hit = key_hit;
      KIND_LOOKUP_SCORE: hit = score_hit;
      default:           hit = 1'b0;
    endcase
  end

  assign first         = hit && !found_q;
  assign found_end     = found_q || first;
  assign found_end_rec = first ? head_rec_i : found_rec_q;
  assign head_next     = wr_en ? wr_rec : head_rec_i;
  assign load_out      = (state_q == ST_DONE) && (!out_valid_q || m_ready_i);

  // Sequencer, bookkeeping of the last entry and result formation.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    count_d     = count_q;
    found_d     = found_q;
    kind_d      = kind_q;
    req_d       = req_q;
    found_rec_d = found_rec_q;
    last_d      = last_q;
    cand_d      = cand_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && m_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          kind_d  = s_kind_i;
          req_d   = s_rec_i;
          found_d = 1'b0;
          idx_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        idx_d = idx_q + 1'b1;
        if (first) begin
          found_d     = 1'b1;
          found_rec_d = head_rec_i;
        end
        // The shadow copy always holds the entry at the top of the table.
        if ((kind_q == KIND_ADD) && wr_en) begin
          last_d = req_q;
        end
        if ((kind_q == KIND_REVISE) && first && is_last) begin
          last_d = wr_rec;
        end
        if ((kind_q == KIND_DELETE) && is_prev) begin
          cand_d = head_next;
        end
        if (last_step) begin
          idx_d        = '0;
          state_d      = ST_DONE;
          res_d.status = found_end ? STATUS_OK : STATUS_NOT_FOUND;
          res_d.found  = '0;
          unique case (kind_q)
            KIND_ADD: begin
              if (found_end) begin
                res_d.status = STATUS_DUPLICATE;
              end else if (count_q == CNT_W'(TABLE_DEPTH)) begin
                res_d.status = STATUS_FULL;
              end else begin
                res_d.status = STATUS_OK;
                count_d      = count_q + 1'b1;
              end
            end
            KIND_DELETE: begin
              if (found_end) begin
                count_d = count_q - 1'b1;
                last_d  = cand_q;
              end
            end
            KIND_REVISE: res_d.found = '0;
            KIND_LOOKUP_KEY, KIND_LOOKUP_SCORE: begin
              if (found_end) begin
                res_d.found = found_end_rec;
              end
            end
            default: res_d.status = STATUS_NOT_FOUND;
          endcase
          res_d.total = TOTAL_W'(count_d);
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    req_q       <= req_d;
    found_rec_q <= found_rec_d;
    last_q      <= last_d;
    cand_q      <= cand_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  assign s_ready_o        = state_q == ST_IDLE;
  assign ring_ctl_o.shift = scanning;
  assign ring_ctl_o.wr_en = scanning && wr_en;
  assign wr_rec_o         = wr_rec;
  assign m_valid_o        = out_valid_q;
  assign m_result_o       = out_q;

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above capacity");

  // The fill count moves only at the end of a scan.
  a_count_when: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $past(state_q) == ST_SCAN)
    else $error("entry count changed outside a scan");

  // The fill count moves by one entry at a time.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |->
      (count_q == $past(count_q) + 1'b1) || (count_q == $past(count_q) - 1'b1))
    else $error("entry count jumped");

  // An accepted word starts a scan with the ring at entry zero.
  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid_i && s_ready_o |=> (state_q == ST_SCAN) && (idx_q == '0))
    else $error("scan did not start at entry zero");

endmodule

@@ src/keyed_record_table_core.sv @@
// An accepted word gives its result on m_axis once the record ring has turned a full circle.
// A new request is taken only after the previous result has moved to the output register; the record ring turns once
// per request, one entry past the head comparator per cycle.
// A finished result waits in the output register while the next request is scanned.
// Reset clears the entry count and the handshakes; record contents are not cleared.
module keyed_record_table_core
  import krt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // key, name_bytes, score_value
  input  logic [KIND_W-1:0]     s_axis_tuser,  // kind
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // status, found_key, found_name,
                                               // found_score, entry_total, zero pad
);

  rec_t      in_rec;
  rec_t      wr_rec;
  rec_t      tail_rec;
  rec_t      cell_rec [TABLE_DEPTH];
  ring_ctl_t ring_ctl;
  result_t   result;

  // Unpack the request word.
  assign in_rec.key   = s_axis_tdata[KEY_W-1:0];
  assign in_rec.name  = s_axis_tdata[KEY_W+NAME_W-1:KEY_W];
  assign in_rec.score = s_axis_tdata[IN_FIELDS_W-1:KEY_W+NAME_W];

  krt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .s_kind_i   (s_axis_tuser),
    .s_rec_i    (in_rec),
    .head_rec_i (cell_rec[0]),
    .ring_ctl_o (ring_ctl),
    .wr_rec_o   (wr_rec),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_result_o (result)
  );

  // The head record re-enters at the tail, rewritten where the request says so.
  assign tail_rec = ring_ctl.wr_en ? wr_rec : cell_rec[0];

  // Row of record cells; each passes its record toward the head.
  for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
    rec_t next_rec;
    if (j == TABLE_DEPTH - 1) begin : g_tail
      assign next_rec = tail_rec;
    end else begin : g_body
      assign next_rec = cell_rec[j+1];
    end
    krt_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (ring_ctl.shift),
      .rec_i   (next_rec),
      .rec_o   (cell_rec[j])
    );
  end

  // Pack the result word.
  assign m_axis_tdata = OUT_DATA_W'({result.total, result.found.score,
                                     result.found.name, result.found.key,
                                     result.status});

endmodule
